// ===== rtl/dref_pkg.sv =====
`timescale 1ns / 1ps

package dref_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 11;
    localparam int LEN_W       = 12;
    localparam int COEFF_W     = 16;
    localparam int COEFF_FRAC  = 8;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int RESULT_W    = 32;
    localparam int VALUE_SHIFT = 16;

    localparam int PROD_W     = COEFF_W + SAMPLE_W;
    localparam int NUM_W      = PROD_W + COEFF_FRAC;
    localparam int QUOT_W     = RESULT_W;
    localparam int HI_W       = NUM_W - QUOT_W;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = QUOT_W / DIV_STEP;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    localparam int MAX_POINTS_DEF  = 2048;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [COEFF_W-1:0] COEFF_RESET  = 16'd256;
    localparam logic [LEN_W-1:0]   POINTS_RESET = 12'd512;

    typedef enum logic [CMD_W-1:0] {
        CMD_CORRECT   = 2'd0,
        CMD_LOAD_DARK = 2'd1,
        CMD_LOAD_REF  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_PASS           = 2'd0,
        MODE_DARK_SUB       = 2'd1,
        MODE_REF_RATIO      = 2'd2,
        MODE_DARK_REF_RATIO = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_COEFF  = 2'd1,
        CFG_POINTS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                valid;
        logic [INDEX_W-1:0]  index;
        logic                mism;
        logic                ratio;
        logic                zero_den;
        logic                sat;
        logic [SAMPLE_W-1:0] pass_val;
        logic [SAMPLE_W-1:0] den;
        logic [SAMPLE_W-1:0] rem;
        logic [QUOT_W-1:0]   work;
    } div_word_t;

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic [INDEX_W-1:0]  index;
        logic                mism;
        logic                sat;
    } result_t;

    // one restoring step: numerator bits shift out of work, quotient bits shift in
    function automatic div_word_t div_step(div_word_t w);
        logic [SAMPLE_W:0] trial;
        div_word_t         r;
        r     = w;
        trial = {w.rem, w.work[QUOT_W-1]};
        if (trial >= {1'b0, w.den}) begin
            r.rem  = SAMPLE_W'(trial - {1'b0, w.den});
            r.work = {w.work[QUOT_W-2:0], 1'b1};
        end else begin
            r.rem  = trial[SAMPLE_W-1:0];
            r.work = {w.work[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/spectrum_dark_reference_correction_core.sv =====
`timescale 1ns / 1ps

// Dark and reference correction for spectrometer points. Words with tuser 1 or 2 load one
// point of the dark or reference spectrum into on-chip RAM (tlast on a load sets that
// spectrum's length to index + 1); tuser 0 corrects one sample point and returns one result
// word, tuser 3 is dropped. The core takes one word per clock while its skid entry is empty;
// a corrected point passes three front stages (RAM read, operand select, coefficient multiply),
// a 16-stage divider retiring two quotient bits per stage and the output register. A two-entry
// output buffer lets input continue while a result waits, and m_tready low for long enough
// stalls the whole pipeline. The stores are not cleared at reset, so correcting a point whose
// dark or reference entry was never loaded gives an undefined value. The user must write cfg
// port registers only while no word is in flight; the core itself does not enforce this.
module spectrum_dark_reference_correction_core #(
    parameter int MAX_POINTS  = dref_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = dref_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dref_pkg::S_TDATA_W-1:0]      s_tdata,   // point_index, intensity
    input  logic [dref_pkg::S_TUSER_W-1:0]      s_tuser,   // command
    input  logic                                s_tlast,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dref_pkg::M_TDATA_W-1:0]      m_tdata,   // corrected_value, out_index
    output logic [dref_pkg::M_TUSER_W-1:0]      m_tuser,   // length_mismatch, saturated

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dref_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dref_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dref_pkg::mode_t                  mode_reg;
    logic [dref_pkg::COEFF_W-1:0]     coeff_reg;
    logic [dref_pkg::LEN_W-1:0]       points_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= dref_pkg::MODE_PASS;
            coeff_reg  <= dref_pkg::COEFF_RESET;
            points_reg <= dref_pkg::POINTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dref_pkg::CFG_MODE: begin
                    mode_reg <= dref_pkg::mode_t'(cfg_data[1:0]);
                end
                dref_pkg::CFG_COEFF: begin
                    coeff_reg <= cfg_data[dref_pkg::COEFF_W-1:0];
                end
                dref_pkg::CFG_POINTS: begin
                    points_reg <= cfg_data[dref_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic                en;
    logic                skid_valid_reg;
    dref_pkg::div_word_t front_word;
    dref_pkg::div_word_t div_word;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    dref_front #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_accept       (s_tvalid && s_tready),
        .in_cmd          (s_tuser),
        .in_index        (s_tdata[dref_pkg::INDEX_W-1:0]),
        .in_intensity    (s_tdata[dref_pkg::INDEX_W +: dref_pkg::SAMPLE_W]),
        .in_last         (s_tlast),
        .mode            (mode_reg),
        .cal_coeff       (coeff_reg),
        .spectrum_points (points_reg),
        .div_out         (front_word)
    );

    dref_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .div_in  (front_word),
        .div_out (div_word)
    );

    dref_pkg::result_t result;

    always_comb begin
        result.index = div_word.index;
        result.mism  = div_word.mism;
        result.sat   = div_word.ratio && !div_word.zero_den && div_word.sat;
        if (!div_word.ratio) begin
            result.value = {div_word.pass_val, {dref_pkg::VALUE_SHIFT{1'b0}}};
        end else if (div_word.zero_den) begin
            result.value = '0;
        end else if (div_word.sat) begin
            result.value = '1;
        end else begin
            result.value = div_word.work;
        end
    end

    // output register with a skid entry behind it
    logic              out_valid_reg;
    dref_pkg::result_t out_data_reg;
    dref_pkg::result_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (en && div_word.valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= div_word.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_tready) begin
            if (en && div_word.valid) begin
                skid_data_reg <= result;
            end
        end else if (skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dref_pkg::M_TDATA_W'({out_data_reg.index, out_data_reg.value});
    assign m_tuser  = {out_data_reg.sat, out_data_reg.mism};

endmodule

// ===== rtl/dref_ram.sv =====
`timescale 1ns / 1ps

module dref_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dref_front.sv =====
`timescale 1ns / 1ps

module dref_front #(
    parameter int MAX_POINTS  = dref_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = dref_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_accept,
    input  logic [dref_pkg::CMD_W-1:0]     in_cmd,
    input  logic [dref_pkg::INDEX_W-1:0]   in_index,
    input  logic [dref_pkg::SAMPLE_W-1:0]  in_intensity,
    input  logic                           in_last,
    input  dref_pkg::mode_t                mode,
    input  logic [dref_pkg::COEFF_W-1:0]   cal_coeff,
    input  logic [dref_pkg::LEN_W-1:0]     spectrum_points,
    output dref_pkg::div_word_t            div_out
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int IW = ((AW > dref_pkg::INDEX_W) ? AW : dref_pkg::INDEX_W) + 1;
    localparam int SW = (SAMPLE_BITS < dref_pkg::SAMPLE_W) ? SAMPLE_BITS : dref_pkg::SAMPLE_W;

    // accept stage
    logic [IW-1:0]                  index_ext;
    logic [AW-1:0]                  addr;
    logic                           in_range;
    logic [dref_pkg::SAMPLE_W-1:0]  sample;
    logic                           dark_we;
    logic                           ref_we;
    logic                           is_sample;
    logic                           need_dark;
    logic                           need_ref;
    logic                           dark_ok;
    logic                           ref_ok;
    logic                           mism;
    logic [dref_pkg::LEN_W-1:0]     load_len;
    logic [dref_pkg::LEN_W-1:0]     dark_len_reg;
    logic [dref_pkg::LEN_W-1:0]     ref_len_reg;
    logic [SW-1:0]                  dark_q;
    logic [SW-1:0]                  ref_q;

    assign index_ext = IW'(in_index);
    assign addr      = index_ext[AW-1:0];
    assign in_range  = index_ext < IW'(MAX_POINTS);
    assign sample    = dref_pkg::SAMPLE_W'(in_intensity[SW-1:0]);
    assign dark_we   = in_accept && (in_cmd == dref_pkg::CMD_LOAD_DARK) && in_range;
    assign ref_we    = in_accept && (in_cmd == dref_pkg::CMD_LOAD_REF) && in_range;
    assign is_sample = in_accept && (in_cmd == dref_pkg::CMD_CORRECT);
    assign load_len  = dref_pkg::LEN_W'(in_index) + dref_pkg::LEN_W'(1);

    assign need_dark = mode inside {dref_pkg::MODE_DARK_SUB, dref_pkg::MODE_DARK_REF_RATIO};
    assign need_ref  = mode inside {dref_pkg::MODE_REF_RATIO, dref_pkg::MODE_DARK_REF_RATIO};
    assign dark_ok   = (dark_len_reg != '0) && (dark_len_reg == spectrum_points);
    assign ref_ok    = (ref_len_reg != '0) && (ref_len_reg == spectrum_points);
    assign mism      = (mode != dref_pkg::MODE_PASS)
                       && (!in_range || (need_dark && !dark_ok) || (need_ref && !ref_ok));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_len_reg <= '0;
            ref_len_reg  <= '0;
        end else begin
            if (dark_we && in_last) begin
                dark_len_reg <= load_len;
            end
            if (ref_we && in_last) begin
                ref_len_reg <= load_len;
            end
        end
    end

    dref_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_POINTS)
    ) u_dark_ram (
        .aclk  (aclk),
        .we    (dark_we),
        .waddr (addr),
        .wdata (in_intensity[SW-1:0]),
        .re    (en),
        .raddr (addr),
        .rdata (dark_q)
    );

    dref_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_POINTS)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (addr),
        .wdata (in_intensity[SW-1:0]),
        .re    (en),
        .raddr (addr),
        .rdata (ref_q)
    );

    // stage 1: stores read back, differences
    logic                           s1_valid_reg;
    logic [dref_pkg::INDEX_W-1:0]   s1_index_reg;
    logic [dref_pkg::SAMPLE_W-1:0]  s1_sample_reg;
    logic                           s1_mism_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= is_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_index_reg  <= in_index;
            s1_sample_reg <= sample;
            s1_mism_reg   <= mism;
        end
    end

    logic [dref_pkg::SAMPLE_W-1:0]  dark_val;
    logic [dref_pkg::SAMPLE_W-1:0]  ref_val;
    logic [dref_pkg::SAMPLE_W-1:0]  num_diff;
    logic [dref_pkg::SAMPLE_W-1:0]  den_diff;
    logic                           s2_ratio_next;
    logic [dref_pkg::SAMPLE_W-1:0]  s2_num_next;
    logic [dref_pkg::SAMPLE_W-1:0]  s2_den_next;
    logic [dref_pkg::SAMPLE_W-1:0]  s2_pass_next;

    assign dark_val = dref_pkg::SAMPLE_W'(dark_q);
    assign ref_val  = dref_pkg::SAMPLE_W'(ref_q);

    always_comb begin
        num_diff      = (s1_sample_reg > dark_val) ? s1_sample_reg - dark_val : '0;
        den_diff      = (ref_val > dark_val) ? ref_val - dark_val : '0;
        s2_ratio_next = !s1_mism_reg
                        && (mode inside {dref_pkg::MODE_REF_RATIO,
                                         dref_pkg::MODE_DARK_REF_RATIO});
        if (mode == dref_pkg::MODE_DARK_REF_RATIO) begin
            s2_num_next = num_diff;
            s2_den_next = den_diff;
        end else begin
            s2_num_next = s1_sample_reg;
            s2_den_next = ref_val;
        end
        if ((mode == dref_pkg::MODE_DARK_SUB) && !s1_mism_reg) begin
            s2_pass_next = num_diff;
        end else begin
            s2_pass_next = s1_sample_reg;
        end
    end

    // stage 2: coefficient multiply
    logic                           s2_valid_reg;
    logic [dref_pkg::INDEX_W-1:0]   s2_index_reg;
    logic                           s2_mism_reg;
    logic                           s2_ratio_reg;
    logic [dref_pkg::SAMPLE_W-1:0]  s2_num_reg;
    logic [dref_pkg::SAMPLE_W-1:0]  s2_den_reg;
    logic [dref_pkg::SAMPLE_W-1:0]  s2_pass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_index_reg <= s1_index_reg;
            s2_mism_reg  <= s1_mism_reg;
            s2_ratio_reg <= s2_ratio_next;
            s2_num_reg   <= s2_num_next;
            s2_den_reg   <= s2_den_next;
            s2_pass_reg  <= s2_pass_next;
        end
    end

    logic [dref_pkg::PROD_W-1:0] s3_prod_next;

    assign s3_prod_next = dref_pkg::PROD_W'(cal_coeff) * dref_pkg::PROD_W'(s2_num_reg);

    // stage 3: divider setup and overflow check
    logic                           s3_valid_reg;
    logic [dref_pkg::INDEX_W-1:0]   s3_index_reg;
    logic                           s3_mism_reg;
    logic                           s3_ratio_reg;
    logic [dref_pkg::PROD_W-1:0]    s3_prod_reg;
    logic [dref_pkg::SAMPLE_W-1:0]  s3_den_reg;
    logic [dref_pkg::SAMPLE_W-1:0]  s3_pass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_index_reg <= s2_index_reg;
            s3_mism_reg  <= s2_mism_reg;
            s3_ratio_reg <= s2_ratio_reg;
            s3_prod_reg  <= s3_prod_next;
            s3_den_reg   <= s2_den_reg;
            s3_pass_reg  <= s2_pass_reg;
        end
    end

    logic [dref_pkg::HI_W-1:0] num_hi;
    logic                      zero_den;

    assign num_hi   = s3_prod_reg[dref_pkg::PROD_W-1 -: dref_pkg::HI_W];
    assign zero_den = (s3_den_reg == '0);

    always_comb begin
        div_out.valid    = s3_valid_reg;
        div_out.index    = s3_index_reg;
        div_out.mism     = s3_mism_reg;
        div_out.ratio    = s3_ratio_reg;
        div_out.zero_den = zero_den;
        // quotient of 2^32 or more cannot be represented
        div_out.sat      = !zero_den && (dref_pkg::SAMPLE_W'(num_hi) >= s3_den_reg);
        div_out.pass_val = s3_pass_reg;
        div_out.den      = s3_den_reg;
        div_out.rem      = dref_pkg::SAMPLE_W'(num_hi);
        div_out.work     = {s3_prod_reg[dref_pkg::QUOT_W-dref_pkg::COEFF_FRAC-1:0],
                            {dref_pkg::COEFF_FRAC{1'b0}}};
    end

endmodule

// ===== rtl/dref_div.sv =====
`timescale 1ns / 1ps

module dref_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  dref_pkg::div_word_t div_in,
    output dref_pkg::div_word_t div_out
);

    localparam int N = dref_pkg::DIV_STAGES;

    logic [N-1:0]        valid_reg;
    dref_pkg::div_word_t stage_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-2:0], div_in.valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        dref_pkg::div_word_t stage_src;
        dref_pkg::div_word_t stage_next;

        if (k == 0) begin : g_first
            assign stage_src = div_in;
        end else begin : g_rest
            assign stage_src = stage_reg[k-1];
        end

        always_comb begin
            stage_next = stage_src;
            for (int j = 0; j < dref_pkg::DIV_STEP; j++) begin
                stage_next = dref_pkg::div_step(stage_next);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    always_comb begin
        div_out       = stage_reg[N-1];
        div_out.valid = valid_reg[N-1];
    end

endmodule
